### design/mp2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared widths, register indexes, status codes and helpers of the streaming
// two-dimensional max pooling core.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int CFG_W           = 11;   // width of the dimension registers
  localparam int WIN_RAW_W       = 4;    // written width of window_size
  localparam int REG_IDX_W       = 3;
  localparam int CNT_W           = 10;   // column, row and channel counters
  localparam int XW              = 12;   // width for counter/bound compares
  localparam int DIM_LIMIT       = 1024;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_POOL_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = 2;
  localparam int FIFO_CNT_W      = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLANE_COUNT  = 3'd0,
    REG_PLANE_HEIGHT = 3'd1,
    REG_PLANE_WIDTH  = 3'd2,
    REG_WINDOW_SIZE  = 3'd3,
    REG_STEP_SIZE    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_WINDOW = 2'd1,
    STATUS_COUNT  = 2'd2
  } status_e;

  // zero reads as one, large values saturate at hi
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/mp2d_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mp2d_rem_unit #(
  parameter int DIVIDEND_W = 10,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [CW-1:0]         cnt_q;
  logic [DIVIDEND_W-1:0] sh_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  rem_d;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    trial = {rem_q, sh_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = DIVISOR_W'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = DIVISOR_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << 1;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### design/mp2d_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_line_store
// Row store split in one bank per window row. All banks are read at the same
// column when rd_en_i is high; the bank named by wr_bank_i is written at that column.
// ----------------------------------------------------------------------------
module mp2d_line_store #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_POOL    = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int ADDR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int BANK_W      = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [BANK_W-1:0]                   wr_bank_i,
  input  logic [SAMPLE_BITS-1:0]              wr_data_i,
  input  logic                                rd_en_i,
  input  logic [ADDR_W-1:0]                   addr_i,
  output logic [MAX_POOL-1:0][SAMPLE_BITS-1:0] rd_data_o
);

  for (genvar b = 0; b < MAX_POOL; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == BANK_W'(b))) begin
        mem[addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[addr_i];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule
`default_nettype wire

### design/mp2d_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_out_fifo
// Small result queue between the pooling pipeline and the output channel.
// ----------------------------------------------------------------------------
module mp2d_out_fifo #(
  parameter int DATA_W = 19
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [DATA_W-1:0]               push_data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output logic [DATA_W-1:0]               data_o,
  output logic [mp2d_pkg::FIFO_CNT_W-1:0] count_o
);

  import mp2d_pkg::*;

  logic [DATA_W-1:0]     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
`default_nettype wire

### design/max_pool_2d_stream_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_stream_core
// Streaming 2-D max pooling over a channel-major, raster-ordered tensor.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, always ready) writes plane_count,
//   plane_height, plane_width, window_size and step_size by index; write only
//   while no item is in flight. Each write starts a bit-serial recompute of
//   the row slot and stride phases from the live counters: input is stalled
//   until the results of the recompute after the last write are loaded.
//   Input items (sample_i, is_final_i) are taken when in_valid_i is high and
//   in_stall_o low, one per cycle. Each item writes its sample to the banked
//   line store and reads the other window rows at the same column in the same
//   cycle; the read data returns in the next cycle to build the column
//   maximum, and the window maximum is formed the cycle after that. A result
//   passes through stage 1, stage 2 and the result queue before it shows on
//   out_valid_o, and waits in a 4-entry queue while out_stall_i is high;
//   the input also stalls when that queue plus the results in flight could
//   fill it. Reset sets all registers to 1, clears the counters and the
//   queue; line store contents are undefined until written.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_core #(
  parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_POOL    = mp2d_pkg::MAX_POOL_DEF,
  parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mp2d_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [mp2d_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  input  logic                           is_final_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  pooled_value_o,
  output logic                           is_last_o,
  output logic [1:0]                     status_o
);

  import mp2d_pkg::*;

  localparam int W_LIMIT = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int PW      = $clog2(MAX_POOL + 1);
  localparam int SW      = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RES_W   = SAMPLE_BITS + 3;

  // ---------------- configuration ----------------
  logic                 cfg_wr;
  logic [CFG_W-1:0]     chans_q, height_q, width_q, step_q;
  logic [PW-1:0]        win_q;
  logic [PW-1:0]        win_d;
  logic [WIN_RAW_W-1:0] win_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign win_raw     = cfg_data_i[WIN_RAW_W-1:0];

  always_comb begin
    if (win_raw == '0) begin
      win_d = PW'(1);
    end else if (int'(win_raw) > MAX_POOL) begin
      win_d = PW'(MAX_POOL);
    end else begin
      win_d = PW'(win_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      width_q  <= CFG_W'(1);
      step_q   <= CFG_W'(1);
      win_q    <= PW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_PLANE_COUNT:  chans_q  <= clamp_dim(cfg_data_i, CFG_W'(DIM_LIMIT));
        REG_PLANE_HEIGHT: height_q <= clamp_dim(cfg_data_i, CFG_W'(DIM_LIMIT));
        REG_PLANE_WIDTH:  width_q  <= clamp_dim(cfg_data_i, CFG_W'(W_LIMIT));
        REG_WINDOW_SIZE:  win_q    <= win_d;
        REG_STEP_SIZE:    step_q   <= clamp_dim(cfg_data_i, CFG_W'(DIM_LIMIT));
        default: ;
      endcase
    end
  end

  // ---------------- position state ----------------
  logic [CNT_W-1:0] col_q, row_q, chan_q;
  logic             ovf_q;
  logic [SW-1:0]    slot_q;          // row mod window
  logic [CNT_W-1:0] rph_q, cph_q;    // stride phase of window origin row/col

  logic [XW-1:0] col_x, row_x, chan_x, p_x, s_x, h_x, w_x, c_x;
  logic          accept, row_full, col_full, col_ok, do_cm, emit, last;
  logic          end_row, end_plane, at_end, err_cnt, err_win, res;
  logic [MAX_POOL-1:0] win_mask, bank_mask;
  logic [SW-1:0]    slot_nx;
  logic [CNT_W-1:0] rph_nx, cph_nx;
  status_e          status_d;

  assign col_x  = XW'(col_q);
  assign row_x  = XW'(row_q);
  assign chan_x = XW'(chan_q);
  assign p_x    = XW'(win_q);
  assign s_x    = XW'(step_q);
  assign h_x    = XW'(height_q);
  assign w_x    = XW'(width_q);
  assign c_x    = XW'(chans_q);

  always_comb begin
    row_full  = (row_x + XW'(1)) >= p_x;
    col_full  = (col_x + XW'(1)) >= p_x;
    col_ok    = int'(col_q) < MAX_WIDTH;
    do_cm     = !ovf_q && row_full;
    emit      = do_cm && col_full && (rph_q == '0) && (cph_q == '0);
    last      = ((chan_x + XW'(1)) >= c_x) && ((row_x + s_x) >= h_x)
                && ((col_x + s_x) >= w_x);
    end_row   = (col_x + XW'(1)) >= w_x;
    end_plane = end_row && ((row_x + XW'(1)) >= h_x);
    at_end    = !ovf_q && end_plane && ((chan_x + XW'(1)) >= c_x);
    err_cnt   = is_final_i && (ovf_q || !at_end);
    err_win   = is_final_i && !err_cnt && ((p_x > h_x) || (p_x > w_x));
    res       = emit || err_cnt || err_win;
    priority if (err_cnt) begin
      status_d = STATUS_COUNT;
    end else if (err_win) begin
      status_d = STATUS_WINDOW;
    end else begin
      status_d = STATUS_OK;
    end
    for (int k = 0; k < MAX_POOL; k++) begin
      win_mask[k]  = k < int'(win_q);
      bank_mask[k] = col_ok && win_mask[k] && (k != int'(slot_q));
    end
    slot_nx = ((XW'(slot_q) + XW'(1)) >= p_x) ? '0 : slot_q + SW'(1);
    if ((row_x + XW'(2)) <= p_x) begin
      rph_nx = '0;
    end else begin
      rph_nx = ((XW'(rph_q) + XW'(1)) >= s_x) ? '0 : rph_q + CNT_W'(1);
    end
    if ((col_x + XW'(2)) <= p_x) begin
      cph_nx = '0;
    end else begin
      cph_nx = ((XW'(cph_q) + XW'(1)) >= s_x) ? '0 : cph_q + CNT_W'(1);
    end
  end

  // ---------------- slot/phase recompute after config writes ----------------
  logic             rc_go_q, recalc_q, recalc_load;
  logic             busy_slot, busy_rph, busy_cph;
  logic [CFG_W-1:0] rem_slot, rem_rph, rem_cph;
  logic [CNT_W-1:0] div_rph, div_cph;

  assign div_rph = row_full ? CNT_W'(row_x + XW'(1) - p_x) : '0;
  assign div_cph = col_full ? CNT_W'(col_x + XW'(1) - p_x) : '0;
  assign recalc_load = recalc_q && !rc_go_q && !cfg_wr
                       && !busy_slot && !busy_rph && !busy_cph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_go_q  <= 1'b0;
      recalc_q <= 1'b0;
    end else if (cfg_wr) begin
      rc_go_q  <= 1'b1;
      recalc_q <= 1'b1;
    end else begin
      rc_go_q <= 1'b0;
      if (recalc_load) begin
        recalc_q <= 1'b0;
      end
    end
  end

  mp2d_rem_unit #(.DIVIDEND_W(CNT_W), .DIVISOR_W(CFG_W)) u_rem_slot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rc_go_q),
    .dividend_i (row_q),
    .divisor_i  (CFG_W'(win_q)),
    .busy_o     (busy_slot),
    .rem_o      (rem_slot)
  );

  mp2d_rem_unit #(.DIVIDEND_W(CNT_W), .DIVISOR_W(CFG_W)) u_rem_rph (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rc_go_q),
    .dividend_i (div_rph),
    .divisor_i  (step_q),
    .busy_o     (busy_rph),
    .rem_o      (rem_rph)
  );

  mp2d_rem_unit #(.DIVIDEND_W(CNT_W), .DIVISOR_W(CFG_W)) u_rem_cph (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rc_go_q),
    .dividend_i (div_cph),
    .divisor_i  (step_q),
    .busy_o     (busy_cph),
    .rem_o      (rem_cph)
  );

  // ---------------- counters ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
      ovf_q  <= 1'b0;
      slot_q <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
    end else if (recalc_load) begin
      slot_q <= SW'(rem_slot);
      rph_q  <= CNT_W'(rem_rph);
      cph_q  <= CNT_W'(rem_cph);
    end else if (accept) begin
      if (is_final_i || at_end) begin
        col_q  <= '0;
        row_q  <= '0;
        chan_q <= '0;
        ovf_q  <= at_end && !is_final_i;
        slot_q <= '0;
        rph_q  <= '0;
        cph_q  <= '0;
      end else if (!ovf_q) begin
        if (end_plane) begin
          col_q  <= '0;
          row_q  <= '0;
          chan_q <= chan_q + CNT_W'(1);
          slot_q <= '0;
          rph_q  <= '0;
          cph_q  <= '0;
        end else if (end_row) begin
          col_q  <= '0;
          row_q  <= row_q + CNT_W'(1);
          slot_q <= slot_nx;
          rph_q  <= rph_nx;
          cph_q  <= '0;
        end else begin
          col_q <= col_q + CNT_W'(1);
          cph_q <= cph_nx;
        end
      end
    end
  end

  // ---------------- line store ----------------
  logic                                 ls_en;
  logic [MAX_POOL-1:0][SAMPLE_BITS-1:0] rd_data;

  assign ls_en = accept && !ovf_q && col_ok;

  mp2d_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_POOL    (MAX_POOL),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_W      (AW),
    .BANK_W      (SW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (ls_en),
    .wr_bank_i (slot_q),
    .wr_data_i (sample_i),
    .rd_en_i   (ls_en),
    .addr_i    (AW'(col_q)),
    .rd_data_o (rd_data)
  );

  // ---------------- stage 1: column maximum ----------------
  logic                          s1_res_q, s1_cm_q, s1_last_q;
  status_e                       s1_status_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [MAX_POOL-1:0]           s1_bank_mask_q, s1_win_mask_q;
  logic signed [SAMPLE_BITS-1:0] cm;
  logic signed [SAMPLE_BITS-1:0] cmw_q [MAX_POOL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_res_q <= 1'b0;
      s1_cm_q  <= 1'b0;
    end else begin
      s1_res_q <= accept && res;
      s1_cm_q  <= accept && do_cm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q    <= sample_i;
      s1_bank_mask_q <= bank_mask;
      s1_win_mask_q  <= win_mask;
      s1_last_q      <= (status_d != STATUS_OK) || last;
      s1_status_q    <= status_d;
    end
  end

  always_comb begin
    cm = s1_sample_q;
    for (int k = 0; k < MAX_POOL; k++) begin
      if (s1_bank_mask_q[k] && ($signed(rd_data[k]) > cm)) begin
        cm = $signed(rd_data[k]);
      end
    end
  end

  // newest column maximum at entry 0
  always_ff @(posedge clk_i) begin
    if (s1_cm_q) begin
      cmw_q[0] <= cm;
      for (int k = 1; k < MAX_POOL; k++) begin
        cmw_q[k] <= cmw_q[k-1];
      end
    end
  end

  // ---------------- stage 2: window maximum ----------------
  logic                          s2_res_q, s2_last_q;
  status_e                       s2_status_q;
  logic [MAX_POOL-1:0]           s2_win_mask_q;
  logic signed [SAMPLE_BITS-1:0] wmax, res_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_res_q <= 1'b0;
    end else begin
      s2_res_q <= s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_res_q) begin
      s2_win_mask_q <= s1_win_mask_q;
      s2_last_q     <= s1_last_q;
      s2_status_q   <= s1_status_q;
    end
  end

  always_comb begin
    wmax = cmw_q[0];
    for (int k = 1; k < MAX_POOL; k++) begin
      if (s2_win_mask_q[k] && (cmw_q[k] > wmax)) begin
        wmax = cmw_q[k];
      end
    end
    res_value = (s2_status_q != STATUS_OK) ? '0 : wmax;
  end

  // ---------------- result queue ----------------
  logic                  fifo_pop;
  logic [RES_W-1:0]      fifo_data;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign fifo_pop = out_valid_o && !out_stall_i;

  mp2d_out_fifo #(.DATA_W(RES_W)) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_res_q),
    .push_data_i ({res_value, s2_last_q, s2_status_q}),
    .pop_i       (fifo_pop),
    .valid_o     (out_valid_o),
    .data_o      (fifo_data),
    .count_o     (fifo_count)
  );

  assign pooled_value_o = $signed(fifo_data[RES_W-1:3]);
  assign is_last_o      = fifo_data[2];
  assign status_o       = fifo_data[1:0];

  // stall during the recompute, or when queue plus in-flight results could fill the queue
  assign in_stall_o = recalc_q
                      || ((int'(fifo_count) + int'(s1_res_q) + int'(s2_res_q))
                          >= FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_res_q |-> ((int'(fifo_count) < FIFO_DEPTH) || fifo_pop))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_OK)) |-> (pooled_value_o == '0) && is_last_o)
    else $error("error result with nonzero value or without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_final_i) |=> ((col_q == '0) && (row_q == '0) && (chan_q == '0)
                                && !ovf_q))
    else $error("position not cleared after final item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ovf_q) |-> !ls_en)
    else $error("line store written after tensor end");
`endif

endmodule
`default_nettype wire
